/* rtl/tdd_pkg.sv */
package tdd_pkg;

  // Field widths
  localparam int unsigned PRI_W    = 4;
  localparam int unsigned DLY_W    = 8;
  localparam int unsigned FUNC_W   = 2;
  // Only slots 0..15 can be addressed by a 4-bit priority
  localparam int unsigned SLOT_CAP = 16;

  // Request codes carried on the input tuser
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_DEL   = 2'd1,
    FUNC_DELAY = 2'd2,
    FUNC_TICK  = 2'd3
  } func_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic  setup;      // apply add/delete/delay and load its single result
    func_t op;         // which setup operation
    logic  tick_dec;   // decrement installed counters, latch ready mask
    logic  scan_step;  // examine current slot, emit if ready or if no slot is, advance
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a beat this cycle
    logic any_ready;   // ready mask not empty
    logic hit;         // current scan slot is ready
    logic hit_last;    // no ready slot above the current one
  } sts_t;

endpackage

/* rtl/tick_delay_task_dispatcher.sv */
// Tick-driven fixed-priority delay dispatcher.
//
// Input channel (in_*): one beat per request. in_tuser carries the request
// code (add, delete, set delay, tick); in_tdata carries the slot priority and
// the delay value. Result channel (out_*): add, delete and set delay each
// give one beat with tlast set; add reports a refusal in the status bit.
// A tick gives one beat per slot whose counter reached zero, lowest priority
// number first, tlast on the final one, or one beat with tuser low when no
// slot is ready.
// A setup request's result is loaded into the output register on accept.
// A tick first decrements all counters and latches the ready mask, then
// walks the slots one per cycle while the output register is free, up to
// the highest ready slot; that slot walk limits how often ticks are taken.
// One request is in flight at a time; in_tready is low during a tick walk.
// Reset clears every slot's installed flag and counter and empties the
// output register. When the receiver holds out_tready low, the walk pauses
// and the pending beat holds its value.
module tick_delay_task_dispatcher #(
  parameter int unsigned TASKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [3:0] priority_req, [11:4] delay_ticks, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] status, [4:1] task_priority, rest zero
  output logic        out_tuser,  // [0] dispatch_valid
  output logic        out_tlast   // last
);

  // Slots beyond the addressable range can never be installed
  localparam int unsigned NSLOT = (TASKS < tdd_pkg::SLOT_CAP) ? TASKS : tdd_pkg::SLOT_CAP;

  tdd_pkg::cmd_t             cmd;
  tdd_pkg::sts_t             sts;
  logic                      out_status;
  logic [tdd_pkg::PRI_W-1:0] out_pri;

  tdd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_func  (tdd_pkg::func_t'(in_tuser)),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tdd_dp #(
    .NSLOT (NSLOT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_pri       (in_tdata[3:0]),
    .in_dly       (in_tdata[11:4]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_status   (out_status),
    .out_dispatch (out_tuser),
    .out_pri      (out_pri),
    .out_last     (out_tlast)
  );

  assign out_tdata = {3'b000, out_pri, out_status};

endmodule

/* rtl/tdd_ctrl.sv */
module tdd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tdd_pkg::func_t    in_func,
  output logic              in_ready,
  input  tdd_pkg::sts_t     sts,
  output tdd_pkg::cmd_t     cmd
);

  tdd_pkg::state_t state_r;
  tdd_pkg::state_t state_nxt;
  logic            accept;

  assign accept = in_valid && in_ready;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tdd_pkg::ST_IDLE: begin
        if (accept && (in_func == tdd_pkg::FUNC_TICK)) begin
          state_nxt = tdd_pkg::ST_SCAN;
        end
      end
      tdd_pkg::ST_SCAN: begin
        if (sts.out_free && (!sts.any_ready || (sts.hit && sts.hit_last))) begin
          state_nxt = tdd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tdd_pkg::ST_IDLE;
    endcase
  end

  // Outputs; in idle a beat is taken whenever the output register is free
  always_comb begin
    in_ready      = 1'b0;
    cmd.setup     = 1'b0;
    cmd.op        = in_func;
    cmd.tick_dec  = 1'b0;
    cmd.scan_step = 1'b0;
    unique case (state_r)
      tdd_pkg::ST_IDLE: begin
        in_ready     = sts.out_free;
        cmd.setup    = in_valid && sts.out_free && (in_func != tdd_pkg::FUNC_TICK);
        cmd.tick_dec = in_valid && sts.out_free && (in_func == tdd_pkg::FUNC_TICK);
      end
      tdd_pkg::ST_SCAN: begin
        cmd.scan_step = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/tdd_dp.sv */
module tdd_dp #(
  parameter int unsigned NSLOT = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tdd_pkg::cmd_t               cmd,
  output tdd_pkg::sts_t               sts,
  input  logic [tdd_pkg::PRI_W-1:0]   in_pri,
  input  logic [tdd_pkg::DLY_W-1:0]   in_dly,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_status,
  output logic                        out_dispatch,
  output logic [tdd_pkg::PRI_W-1:0]   out_pri,
  output logic                        out_last
);

  localparam int unsigned IDX_W = $clog2(NSLOT);

  logic                      installed_r [NSLOT];
  logic                      installed_nxt [NSLOT];
  logic [tdd_pkg::DLY_W-1:0] cnt_r [NSLOT];
  logic [tdd_pkg::DLY_W-1:0] cnt_nxt [NSLOT];
  logic [NSLOT-1:0]          ready_r;
  logic [NSLOT-1:0]          ready_nxt;
  logic [NSLOT-1:0]          above;
  logic [IDX_W-1:0]          idx_r;
  logic [IDX_W-1:0]          idx_nxt;
  logic [IDX_W-1:0]          slot;
  logic                      in_range;
  logic                      refused;

  logic                      out_valid_r;
  logic                      out_status_r;
  logic                      out_dispatch_r;
  logic [tdd_pkg::PRI_W-1:0] out_pri_r;
  logic                      out_last_r;
  logic                      load;

  // Request slot decode
  assign in_range = {{(32 - tdd_pkg::PRI_W){1'b0}}, in_pri} < NSLOT;
  assign slot     = in_pri[IDX_W-1:0];
  assign refused  = in_range && installed_r[slot];

  // Slot state update: setup ops touch one slot, tick decrements all installed
  always_comb begin
    for (int i = 0; i < NSLOT; i++) begin
      installed_nxt[i] = installed_r[i];
      cnt_nxt[i]       = cnt_r[i];
      ready_nxt[i]     = ready_r[i];
      if (cmd.tick_dec) begin
        ready_nxt[i] = installed_r[i] && (cnt_r[i] == tdd_pkg::DLY_W'(1));
        if (installed_r[i]) begin
          cnt_nxt[i] = cnt_r[i] - tdd_pkg::DLY_W'(1);
        end
      end
    end
    if (cmd.setup && in_range) begin
      case (cmd.op)
        tdd_pkg::FUNC_ADD: begin
          if (!installed_r[slot]) begin
            installed_nxt[slot] = 1'b1;
            cnt_nxt[slot]       = tdd_pkg::DLY_W'(1);
          end
        end
        tdd_pkg::FUNC_DEL: begin
          installed_nxt[slot] = 1'b0;
        end
        tdd_pkg::FUNC_DELAY: begin
          cnt_nxt[slot] = in_dly;
        end
        default: begin
          cnt_nxt[slot] = cnt_r[slot];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        installed_r[i] <= 1'b0;
        cnt_r[i]       <= '0;
      end
    end else begin
      for (int i = 0; i < NSLOT; i++) begin
        installed_r[i] <= installed_nxt[i];
        cnt_r[i]       <= cnt_nxt[i];
      end
    end
  end

  // Scan pointer and ready mask
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.tick_dec) begin
      idx_nxt = '0;
    end else if (cmd.scan_step) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    ready_r <= ready_nxt;
    idx_r   <= idx_nxt;
  end

  // Ready slots above the current scan position
  always_comb begin
    for (int j = 0; j < NSLOT; j++) begin
      above[j] = ready_r[j] && (IDX_W'(j) > idx_r);
    end
  end

  assign sts.any_ready = |ready_r;
  assign sts.hit       = ready_r[idx_r];
  assign sts.hit_last  = ~|above;
  assign sts.out_free  = !out_valid_r || out_ready;

  // Output register
  assign load = cmd.setup || (cmd.scan_step && (sts.hit || !sts.any_ready));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      out_status_r   <= (cmd.op == tdd_pkg::FUNC_ADD) && refused;
      out_dispatch_r <= 1'b0;
      out_pri_r      <= '0;
      out_last_r     <= 1'b1;
    end else if (load) begin
      out_status_r   <= 1'b0;
      out_dispatch_r <= sts.any_ready;
      out_pri_r      <= sts.any_ready ? tdd_pkg::PRI_W'(idx_r) : '0;
      out_last_r     <= !sts.any_ready || sts.hit_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_dispatch = out_dispatch_r;
  assign out_pri      = out_pri_r;
  assign out_last     = out_last_r;

endmodule
